@@ rtl/rpin_pkg.sv @@
// shared types, constants and codes of the radial polynomial inverse block
// used by rpin_div and radial_polynomial_inverse_newton
`timescale 1ns / 1ps
`default_nettype none

package rpin_pkg;

  // number format and iteration limits
  localparam int FRAC_BITS  = 24;
  localparam int MAX_ITER   = 10000;
  localparam int MAX_DEGREE = 5;
  localparam int NUM_COEF   = MAX_DEGREE + 1;
  localparam int ITER_W     = 14;
  localparam int DEG_W      = 3;
  localparam int COEF_W     = 32;
  localparam int ACC_W      = 64;
  localparam int MAG_W      = 62;
  localparam int RAD_W      = 31;

  // divider quotient lengths: newton step and final scale
  localparam int Q_WIDE     = 40;
  localparam int Q_NARROW   = 32;
  localparam int CNT_W      = 6;

  // horner product recombination
  localparam int HP_SH = 32 - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0]        HP_LIM   = 64'h3FFF_FFFF_FFFF_FFFF >> HP_SH;
  localparam logic signed [COEF_W-1:0] ONE_FX  = 32'sh1 <<< FRAC_BITS;

  // convergence test: |delta| * 1e8 < |r|, only possible for |delta| below this span
  localparam logic [31:0] CONV_SCALE = 32'd100000000;
  localparam logic [32:0] CONV_SPAN  = 33'd22;

  // configuration register indexes
  localparam logic [2:0] REG_DEGREE = 3'd0;
  localparam logic [2:0] REG_COEF0  = 3'd1;
  localparam logic [2:0] REG_COEF5  = 3'd6;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOP_ZERO    = 2'd1,
    ST_RADIUS_ZERO = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_ADD,
    S_DCHK,
    S_DIV,
    S_CHK,
    S_FINAL,
    S_FDIV,
    S_DONE
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic             wide;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [Q_WIDE-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/rpin_div.sv @@
// restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_BITS / den)
// depends on rpin_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpin_div
  import rpin_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int SH_WIDE   = Q_WIDE - FRAC_BITS;
  localparam int SH_NARROW = Q_NARROW - FRAC_BITS;

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                ovf_r;
  logic [MAG_W-1:0]    den_r;
  logic [MAG_W-1:0]    rem_r;
  logic [63:0]         sh_r;
  logic [Q_WIDE-1:0]   q_r;

  logic                ovf_chk;
  logic [MAG_W:0]      trial;
  logic                ge;

  // quotient would not fit: num >= den << (Q - FRAC_BITS)
  always_comb begin
    if (req.wide) begin
      ovf_chk = {{SH_WIDE{1'b0}}, req.num} >= {req.den, {SH_WIDE{1'b0}}};
    end else begin
      ovf_chk = {{SH_NARROW{1'b0}}, req.num} >= {req.den, {SH_NARROW{1'b0}}};
    end
  end

  // one restoring step
  assign trial = {rem_r, sh_r[63]};
  assign ge    = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      if (ovf_chk) begin
        cnt_r <= '0;
      end else if (req.wide) begin
        cnt_r <= CNT_W'(Q_WIDE);
      end else begin
        cnt_r <= CNT_W'(Q_NARROW);
      end
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      ovf_r <= ovf_chk;
      q_r   <= '0;
      if (req.wide) begin
        rem_r <= req.num >> SH_WIDE;
        sh_r  <= 64'(req.num) << (64 - SH_WIDE);
      end else begin
        rem_r <= req.num >> SH_NARROW;
        sh_r  <= 64'(req.num) << (64 - SH_NARROW);
      end
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? MAG_W'(trial - {1'b0, den_r}) : trial[MAG_W-1:0];
      sh_r  <= {sh_r[62:0], 1'b0};
      q_r   <= {q_r[Q_WIDE-2:0], ge};
    end
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = q_r;

endmodule

`default_nettype wire

@@ rtl/radial_polynomial_inverse_newton.sv @@
// top level: newton-raphson inverse of a radial polynomial, returns scale = r / w
// depends on rpin_pkg and rpin_div
`timescale 1ns / 1ps
`default_nettype none

// Solves r*(a0 + a1 r + ... + aN r^N) = w for r, starting from r = 1.0, and returns
// scale = r / w in signed Q8.24 with a status code. One transaction is worked on at a
// time; in_tready is high only while the block is idle. Each newton step runs the
// polynomial and its derivative through one shared 32x32 multiplier by horner's rule
// and then through a one-bit-per-cycle divider, which skips its bit loop when the
// step saturates; at most 10000 steps are run before the final division. A zero top
// coefficient or a zero radius goes straight to the result. The user writes
// coefficients and degree through cfg_we/cfg_addr/cfg_data only while the block is
// idle; the block itself does not enforce this.
module radial_polynomial_inverse_newton
  import rpin_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [30:0] target_radius
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] scale_out, [33:32] status
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);

  state_t                    state_r, state_nxt;

  logic [DEG_W-1:0]          deg_r;
  logic signed [COEF_W-1:0]  coef_r [NUM_COEF];

  logic [RAD_W-1:0]          w_r;
  logic [DEG_W-1:0]          n_r;
  logic                      mode_d_r;
  logic [DEG_W-1:0]          idx_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [COEF_W-1:0]  root_r;
  logic [63:0]               lp_r;
  logic [63:0]               hp_r;
  logic signed [ACC_W-1:0]   p_r;
  logic signed [ACC_W-1:0]   d_r;
  logic signed [COEF_W-1:0]  nr_r;
  logic [ITER_W-1:0]         k_r;
  logic [31:0]               res_scale_r;
  status_t                   res_status_r;
  logic                      out_valid_r;
  logic [31:0]               out_scale_r;
  status_t                   out_status_r;

  logic [DEG_W-1:0]          n_in;
  logic [DEG_W-1:0]          rd_idx;
  logic signed [COEF_W-1:0]  crd;
  logic signed [35:0]        dc_prod;
  logic signed [ACC_W-1:0]   dc_val;
  logic signed [ACC_W-1:0]   pc_val;
  logic signed [ACC_W-1:0]   c_add;
  logic                      acc_neg;
  logic [ACC_W-1:0]          acc_abs;
  logic                      root_neg;
  logic [31:0]               root_abs;
  logic [31:0]               mul_a;
  logic [63:0]               prod;
  logic [ACC_W-1:0]          mres;
  logic signed [ACC_W-1:0]   mval;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic [ACC_W-1:0]          p_abs;
  logic [ACC_W-1:0]          d_abs;
  logic [Q_WIDE:0]           step;
  logic signed [41:0]        nr_wide;
  logic signed [COEF_W-1:0]  nr_sat;
  logic signed [32:0]        diff;
  logic [32:0]               dm;
  logic                      conv;
  logic [31:0]               scale_val;
  logic                      in_ok;
  logic                      out_free;
  logic                      top_zero;
  logic                      w_zero;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  rpin_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= (i == 0) ? ONE_FX : '0;
      end
    end else if (cfg_we) begin
      if (cfg_addr == REG_DEGREE) begin
        deg_r <= cfg_data[DEG_W-1:0];
      end else if (cfg_addr >= REG_COEF0 && cfg_addr <= REG_COEF5) begin
        coef_r[3'(cfg_addr - REG_COEF0)] <= cfg_data;
      end
    end
  end

  // effective degree and coefficient read port
  assign n_in = (deg_r > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_r;

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_idx = n_in;
      S_ADD:   rd_idx = mode_d_r ? idx_r : ((idx_r == '0) ? n_r : idx_r - 1'b1);
      default: rd_idx = n_r;
    endcase
  end

  assign crd     = coef_r[rd_idx];
  assign dc_prod = crd * $signed({1'b0, 3'(rd_idx + 3'd1)});
  assign dc_val  = ACC_W'(dc_prod);
  assign pc_val  = (!mode_d_r && idx_r == '0) ? -$signed({33'b0, w_r}) : ACC_W'(crd);
  assign c_add   = mode_d_r ? dc_val : pc_val;

  // shared multiplier: low then high half of |acc| times |r|
  assign acc_neg  = acc_r[ACC_W-1];
  assign acc_abs  = acc_neg ? ACC_W'(-acc_r) : acc_r;
  assign root_neg = root_r[COEF_W-1];
  assign root_abs = root_neg ? (~root_r + 32'd1) : root_r;
  assign mul_a    = (state_r == S_MLO) ? acc_abs[31:0] : {2'b0, acc_abs[MAG_W-1:32]};
  assign prod     = mul_a * root_abs;

  // horner step: truncated product, sign, add coefficient, saturate
  always_comb begin
    if (hp_r > HP_LIM) begin
      mres = ACC_LIM;
    end else begin
      mres = (hp_r << HP_SH) + (lp_r >> FRAC_BITS);
      if (mres > ACC_LIM) begin
        mres = ACC_LIM;
      end
    end
    mval = (acc_neg ^ root_neg) ? -$signed(mres) : $signed(mres);
    sum  = mval + c_add;
    if (sum > ACC_LIM) begin
      acc_sat = ACC_LIM;
    end else if (sum < -ACC_LIM) begin
      acc_sat = -ACC_LIM;
    end else begin
      acc_sat = sum;
    end
  end

  // newton update from the divider result
  assign p_abs   = p_r[ACC_W-1] ? ACC_W'(-p_r) : p_r;
  assign d_abs   = d_r[ACC_W-1] ? ACC_W'(-d_r) : d_r;
  assign step    = div_rsp.ovf ? (41'd1 << Q_WIDE) : {1'b0, div_rsp.quo};
  assign nr_wide = (p_r[ACC_W-1] != d_r[ACC_W-1]) ?
                   42'(root_r) + $signed({1'b0, step}) :
                   42'(root_r) - $signed({1'b0, step});

  always_comb begin
    if (nr_wide > 42'sh0_7FFF_FFFF) begin
      nr_sat = 32'sh7FFF_FFFF;
    end else if (nr_wide < -42'sh0_8000_0000) begin
      nr_sat = 32'sh8000_0000;
    end else begin
      nr_sat = nr_wide[31:0];
    end
  end

  // convergence test on the step just taken
  assign diff = 33'(root_r) - 33'(nr_r);
  assign dm   = diff[32] ? 33'(-diff) : diff;
  assign conv = (dm == '0) ||
                ((dm < CONV_SPAN) && (32'(dm[4:0]) * CONV_SCALE < root_abs));

  // final scale, saturated
  always_comb begin
    if (root_neg) begin
      if (div_rsp.ovf || div_rsp.quo[31:0] > 32'h8000_0000) begin
        scale_val = 32'h8000_0000;
      end else begin
        scale_val = 32'(-div_rsp.quo[31:0]);
      end
    end else begin
      if (div_rsp.ovf || div_rsp.quo[31:0] > 32'h7FFF_FFFF) begin
        scale_val = 32'h7FFF_FFFF;
      end else begin
        scale_val = div_rsp.quo[31:0];
      end
    end
  end

  assign in_ok    = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign top_zero = (crd == '0);
  assign w_zero   = (in_tdata[RAD_W-1:0] == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = (top_zero || w_zero) ? S_DONE : S_MLO;
      S_MLO:   state_nxt = S_MHI;
      S_MHI:   state_nxt = S_ADD;
      S_ADD: begin
        if (idx_r != '0) begin
          state_nxt = S_MLO;
        end else if (!mode_d_r && n_r != '0) begin
          state_nxt = S_MLO;
        end else begin
          state_nxt = S_DCHK;
        end
      end
      S_DCHK:  state_nxt = (d_r == '0) ? S_FINAL : S_DIV;
      S_DIV:   if (div_rsp.done) state_nxt = S_CHK;
      S_CHK: begin
        if (conv || k_r == ITER_W'(MAX_ITER - 1)) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_MLO;
        end
      end
      S_FINAL: state_nxt = S_FDIV;
      S_FDIV:  if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    div_req.start = 1'b0;
    div_req.wide  = 1'b1;
    div_req.num   = p_abs[MAG_W-1:0];
    div_req.den   = d_abs[MAG_W-1:0];
    unique case (state_r)
      S_DCHK:  div_req.start = (d_r != '0);
      S_FINAL: begin
        div_req.start = 1'b1;
        div_req.wide  = 1'b0;
        div_req.num   = MAG_W'(root_abs);
        div_req.den   = MAG_W'(w_r);
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= ONE_FX;
      p_r    <= '0;
      d_r    <= '0;
      k_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ok) begin
            w_r      <= in_tdata[RAD_W-1:0];
            n_r      <= n_in;
            idx_r    <= n_in;
            mode_d_r <= 1'b0;
            acc_r    <= ACC_W'(crd);
            root_r   <= ONE_FX;
            k_r      <= '0;
            res_scale_r <= '0;
            if (top_zero) begin
              res_status_r <= ST_TOP_ZERO;
            end else if (w_zero) begin
              res_status_r <= ST_RADIUS_ZERO;
            end else begin
              res_status_r <= ST_OK;
            end
          end
        end
        S_MLO: lp_r <= prod;
        S_MHI: hp_r <= prod;
        S_ADD: begin
          if (idx_r != '0) begin
            acc_r <= acc_sat;
            idx_r <= idx_r - 1'b1;
          end else if (!mode_d_r) begin
            p_r <= acc_sat;
            if (n_r == '0) begin
              d_r <= dc_val;
            end else begin
              mode_d_r <= 1'b1;
              acc_r    <= dc_val;
              idx_r    <= n_r - 1'b1;
            end
          end else begin
            d_r <= acc_sat;
          end
        end
        S_DIV: if (div_rsp.done) nr_r <= nr_sat;
        S_CHK: begin
          root_r   <= nr_r;
          k_r      <= k_r + 1'b1;
          acc_r    <= ACC_W'(crd);
          idx_r    <= n_r;
          mode_d_r <= 1'b0;
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            res_scale_r  <= scale_val;
            res_status_r <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_scale_r  <= res_scale_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_scale_r};

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// testbench for radial_polynomial_inverse_newton: directed and random radii under
// several coefficient sets, checked against a newton-raphson predictor in a scoreboard
// depends on rpin_pkg and the rtl of radial_polynomial_inverse_newton
`timescale 1ns / 1ps

class scale_scoreboard;
  typedef struct {
    logic [31:0]      scale;
    rpin_pkg::status_t status;
  } scale_result_t;

  scale_result_t expected_q[$];
  int            errors;
  logic [2:0]    degree;
  longint        coef[rpin_pkg::NUM_COEF];

  function new();
    errors = 0;
    degree = 0;
    foreach (coef[i]) coef[i] = 0;
    coef[0] = longint'(1) << rpin_pkg::FRAC_BITS;
  endfunction

  // shadow of the register file
  function void write_reg(logic [2:0] addr, logic [31:0] data);
    if (addr == rpin_pkg::REG_DEGREE) begin
      degree = data[2:0];
    end else if (addr >= rpin_pkg::REG_COEF0 && addr <= rpin_pkg::REG_COEF5) begin
      coef[addr - rpin_pkg::REG_COEF0] = longint'($signed(data));
    end
  endfunction

  function bit [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function longint sat_acc(longint v);
    longint lim;
    lim = rpin_pkg::ACC_LIM;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // truncated fixed point product, saturated
  function longint mul_fx(longint acc, longint r);
    bit        neg;
    bit [63:0] am, rm, hp, lp, res, lim;
    lim = rpin_pkg::ACC_LIM;
    neg = (acc < 0) != (r < 0);
    am  = mag(acc);
    rm  = mag(r);
    hp  = (am >> 32) * rm;
    lp  = (am & 64'hFFFF_FFFF) * rm;
    if (hp > (lim >> (32 - rpin_pkg::FRAC_BITS))) begin
      res = lim;
    end else begin
      res = (hp << (32 - rpin_pkg::FRAC_BITS)) + (lp >> rpin_pkg::FRAC_BITS);
      if (res > lim) res = lim;
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function longint horner(longint c[rpin_pkg::NUM_COEF + 1], int n, longint r);
    longint acc;
    acc = sat_acc(c[n]);
    for (int i = n - 1; i >= 0; i--) acc = sat_acc(mul_fx(acc, r) + c[i]);
    return acc;
  endfunction

  // |num| * 2^frac / |den|, saturated to 2^40
  function bit [63:0] div_fx(bit [63:0] num, bit [63:0] den);
    bit [63:0] q0, rem, q, sat;
    sat = 64'd1 << 40;
    q0  = num / den;
    rem = num % den;
    if (q0 >= (sat >> rpin_pkg::FRAC_BITS)) return sat;
    q = q0 << rpin_pkg::FRAC_BITS;
    for (int i = rpin_pkg::FRAC_BITS - 1; i >= 0; i--) begin
      rem = rem << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // predict the result of one accepted radius
  function void note_radius(logic [30:0] w);
    int            n;
    longint        pc[rpin_pkg::NUM_COEF + 1];
    longint        dc[rpin_pkg::NUM_COEF + 1];
    longint        root, p, d, nr;
    bit [63:0]     stp, diff, qm;
    scale_result_t res;
    n = degree > rpin_pkg::MAX_DEGREE ? rpin_pkg::MAX_DEGREE : int'(degree);
    foreach (pc[i]) pc[i] = 0;
    foreach (dc[i]) dc[i] = 0;
    if (coef[n] == 0) begin
      res.scale  = '0;
      res.status = rpin_pkg::ST_TOP_ZERO;
    end else if (w == 0) begin
      res.scale  = '0;
      res.status = rpin_pkg::ST_RADIUS_ZERO;
    end else begin
      pc[0] = -longint'(w);
      for (int i = 0; i <= n; i++) begin
        pc[i + 1] = coef[i];
        dc[i]     = coef[i] * (i + 1);
      end
      root = longint'(1) << rpin_pkg::FRAC_BITS;
      for (int k = 0; k < rpin_pkg::MAX_ITER; k++) begin
        p = horner(pc, n + 1, root);
        d = horner(dc, n, root);
        if (d == 0) break;
        stp = div_fx(mag(p), mag(d));
        nr  = ((p < 0) != (d < 0)) ? root + longint'(stp) : root - longint'(stp);
        if (nr > 64'sh7FFF_FFFF) nr = 64'sh7FFF_FFFF;
        if (nr < -64'sh8000_0000) nr = -64'sh8000_0000;
        diff = mag(root - nr);
        if (diff == 0 || diff * 64'd100000000 < mag(root)) begin
          root = nr;
          break;
        end
        root = nr;
      end
      qm = (mag(root) << rpin_pkg::FRAC_BITS) / 64'(w);
      if (root < 0) begin
        if (qm > 64'h8000_0000) qm = 64'h8000_0000;
        res.scale = 32'(-longint'(qm));
      end else begin
        if (qm > 64'h7FFF_FFFF) qm = 64'h7FFF_FFFF;
        res.scale = qm[31:0];
      end
      res.status = rpin_pkg::ST_OK;
    end
    expected_q.insert(expected_q.size(), res);
  endfunction

  function void check_result(logic [31:0] scale, logic [1:0] status);
    scale_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result with no transaction pending: scale_out %h status %0d", scale, status);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (scale !== exp_r.scale) begin
      $error("scale_out expected %h actual %h", exp_r.scale, scale);
      errors++;
    end
    if (status !== exp_r.status) begin
      $error("status expected %0d actual %0d", exp_r.status, status);
      errors++;
    end
  endfunction
endclass

module tb;
  import rpin_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000000;
  localparam int RANDOM_ITEMS   = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  scale_scoreboard sb = new();
  bit  no_idle = 1'b0;
  int  quiet_cycles = 0;

  radial_polynomial_inverse_newton uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function bit idle_roll();
    return !no_idle && ($urandom_range(99) < 31);
  endfunction

  // receiver backpressure
  always @(negedge clk) out_tready <= !idle_roll();

  // transaction monitors
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_radius(in_tdata[30:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[31:0], out_tdata[33:32]);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_radius(logic [30:0] w);
    while (idle_roll()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, w};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one write cycle, then cfg_we is dropped again before the task returns
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // well behaved coefficient set: non-negative terms, a0 between 0.5 and 4.0
  task automatic random_coefs();
    logic [2:0] deg;
    deg = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    write_reg(REG_DEGREE, {29'd0, deg});
    write_reg(REG_COEF0, $urandom_range(32'h0400_0000, 32'h0080_0000));
    for (int i = 1; i < NUM_COEF; i++) begin
      write_reg(REG_COEF0 + 3'(i), ($urandom_range(19) == 0) ? 32'd0 : ($urandom & 32'h007F_FFFF));
    end
  endtask

  function logic [30:0] random_radius();
    case ($urandom_range(3))
      0:       return 31'($urandom);
      1:       return 31'($urandom) >> $urandom_range(30, 1);
      2:       return 31'($urandom_range(32'h0400_0000, 32'h0040_0000));
      default: return ($urandom_range(15) == 0) ? 31'd0 : 31'($urandom_range(32'h0100_0000));
    endcase
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients: r = w, plus the zero radius case
    send_radius(31'h0100_0000);
    send_radius(31'd0);
    send_radius(31'h7FFF_FFFF);
    send_radius(31'd1);
    drain();

    // linear extremes, unused high coefficients at the extremes too
    write_reg(REG_COEF0, 32'h8000_0000);
    for (int i = 1; i < NUM_COEF; i++) write_reg(REG_COEF0 + 3'(i), 32'h7FFF_FFFF);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_radius(31'h7FFF_FFFF);
    send_radius(31'd1);
    send_radius(31'h0123_4567);
    drain();
    write_reg(REG_COEF0, 32'h7FFF_FFFF);
    send_radius(31'h7FFF_FFFF);
    send_radius(31'h0000_1000);
    drain();
    write_reg(REG_COEF0, 32'd1);
    send_radius(31'h7FFF_FFFF);
    drain();

    // top coefficient zero wins over zero radius
    for (int i = 1; i < NUM_COEF; i++) write_reg(REG_COEF0 + 3'(i), 32'h8000_0000);
    write_reg(REG_COEF0, 32'h0100_0000);
    write_reg(REG_COEF0 + 3'd2, 32'd0);
    write_reg(REG_DEGREE, 32'd2);
    send_radius(31'd0);
    send_radius(31'h0200_0000);
    drain();

    // zero derivative at the starting point: 2 - 2r
    write_reg(REG_DEGREE, 32'd1);
    write_reg(REG_COEF0, 32'h0200_0000);
    write_reg(REG_COEF0 + 3'd1, 32'hFF00_0000);
    send_radius(31'h0080_0000);
    drain();

    // degree above the maximum clamps to five
    write_reg(REG_COEF0, 32'h0100_0000);
    for (int i = 1; i < NUM_COEF; i++) write_reg(REG_COEF0 + 3'(i), 32'h0008_0000);
    write_reg(REG_DEGREE, 32'hFFFF_FFFF);
    send_radius(31'h0300_0000);
    send_radius(31'h0000_8000);
    drain();
    write_reg(REG_DEGREE, 32'd6);
    send_radius(31'h0180_0000);
    drain();

    // random phases, one with no idling on either side
    for (int ph = 0; ph < 10; ph++) begin
      random_coefs();
      no_idle = (ph == 4);
      for (int k = 0; k < RANDOM_ITEMS / 10; k++) send_radius(random_radius());
      drain();
    end
    no_idle = 1'b0;

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.expected_q.size() != 0) $error("%0d results never arrived", sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/rpin_pkg.sv
rtl/rpin_div.sv
rtl/radial_polynomial_inverse_newton.sv
verif/tb.sv
